// ----- rtl/core/csin_pkg.sv -----
// Package for the CORDIC sine block: field widths, limits and constant-table functions.
package csin_pkg;

  localparam int ANGLE_W     = 18;
  localparam int SINE_W      = 18;
  localparam int IO_FRAC     = 16;
  localparam int GAIN_W      = 31;
  localparam int ANGLE_LIMIT = 102944;
  localparam int SINE_LIMIT  = 65536;

  // atan(2^-idx) with frac fraction bits, rounded half up; evaluated at elaboration
  function automatic longint atan_fixed(int idx, int frac);
    real a;
    a = $atan(2.0 ** (-idx));
    return longint'($floor(a * (2.0 ** frac) + 0.5));
  endfunction

  // reciprocal CORDIC gain 1/K over iters rotations, unsigned Q0.31, floored
  function automatic longint gain_q31(int iters);
    real p;
    p = 1.0;
    for (int i = 0; i < iters; i++) begin
      p = p * (1.0 + 2.0 ** (-2 * i));
    end
    return longint'($floor($pow(p, -0.5) * (2.0 ** GAIN_W)));
  endfunction

endpackage

// ----- rtl/core/cordic_sine_rotation.sv -----
// Unrolled rotation-mode CORDIC sine: one micro-rotation per pipeline stage.
//
//   channel  | handshake       | payload
//   ---------+-----------------+--------------------------------
//   angle in | start_i, busy_o | angle_i  (Q2.16, signed, 18 b)
//   sine out | done_o          | sine_o   (Q2.16, signed, 18 b)
//
// One angle may be started every clock; busy_o stays low.
// Pipeline registers, in order: clamp/scale register, one register per
// micro-rotation, the gain multiply register and the round/saturate register.
// Reset clears the valid bits only; data in flight is dropped.
// Each result is shown for one cycle with done_o and cannot be held off.
module cordic_sine_rotation #(
  parameter int ITERATIONS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [csin_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                 done_o,
  output logic signed [csin_pkg::SINE_W-1:0]   sine_o
);
  import csin_pkg::*;

  // working width: |x|,|y|,|theta| stay below 2^(FRAC_BITS+2)
  localparam int W       = FRAC_BITS + 3;
  localparam int SCALE_W = ANGLE_W + FRAC_BITS;
  localparam int PW      = W + GAIN_W + 1;
  localparam int RSHIFT  = FRAC_BITS + GAIN_W - IO_FRAC;

  localparam logic signed [W-1:0]       X_ONE    = W'(64'd1 << FRAC_BITS);
  localparam logic signed [GAIN_W:0]    GAIN_S   = (GAIN_W + 1)'(gain_q31(ITERATIONS));
  localparam logic signed [PW-1:0]      RND_HALF = PW'(64'd1 << (RSHIFT - 1));
  localparam logic signed [PW-1:0]      SAT_HI   = PW'(SINE_LIMIT);
  localparam logic signed [PW-1:0]      SAT_LO   = -PW'(SINE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] ANG_HI   = ANGLE_W'(ANGLE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] ANG_LO   = -ANGLE_W'(ANGLE_LIMIT);

  logic                valid_q  [ITERATIONS+1];
  logic signed [W-1:0] x_q      [ITERATIONS+1];
  logic signed [W-1:0] y_q      [ITERATIONS+1];
  logic signed [W-1:0] theta_q  [ITERATIONS+1];
  logic signed [W-1:0] target_q [ITERATIONS+1];

  logic signed [ANGLE_W-1:0] angle_clamp;
  logic signed [SCALE_W-1:0] angle_scaled;
  logic signed [W-1:0]       target_d;

  logic                  prod_valid_q;
  logic signed [PW-1:0]  prod_d, prod_q;
  logic signed [PW-1:0]  rounded;
  logic signed [SINE_W-1:0] sine_d, sine_q;
  logic                  done_q;

  assign busy_o = 1'b0;

  // clamp to +-pi/2, then move to FRAC_BITS fraction bits (floor when narrowing)
  always_comb begin
    if (angle_i > ANG_HI) begin
      angle_clamp = ANG_HI;
    end else if (angle_i < ANG_LO) begin
      angle_clamp = ANG_LO;
    end else begin
      angle_clamp = angle_i;
    end
    angle_scaled = (SCALE_W'(angle_clamp) <<< FRAC_BITS) >>> IO_FRAC;
    target_d     = angle_scaled[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]      <= X_ONE;
    y_q[0]      <= '0;
    theta_q[0]  <= '0;
    target_q[0] <= target_d;
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    localparam logic signed [W-1:0] ATAN_I = W'(atan_fixed(i, FRAC_BITS));

    logic signed [W-1:0] dx, dy;
    logic                up;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign up = theta_q[i] < target_q[i];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (up) begin
        theta_q[i+1] <= theta_q[i] + ATAN_I;
        x_q[i+1]     <= x_q[i] - dx;
        y_q[i+1]     <= y_q[i] + dy;
      end else begin
        theta_q[i+1] <= theta_q[i] - ATAN_I;
        x_q[i+1]     <= x_q[i] + dx;
        y_q[i+1]     <= y_q[i] - dy;
      end
      target_q[i+1] <= target_q[i];
    end
  end

  // gain correction
  assign prod_d = y_q[ITERATIONS] * GAIN_S;

  always_comb begin
    rounded = (prod_q + RND_HALF) >>> RSHIFT;
    if (rounded > SAT_HI) begin
      sine_d = SINE_W'(SINE_LIMIT);
    end else if (rounded < SAT_LO) begin
      sine_d = -SINE_W'(SINE_LIMIT);
    end else begin
      sine_d = rounded[SINE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      prod_valid_q <= valid_q[ITERATIONS];
      done_q       <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sine_q <= sine_d;
  end

  assign done_o = done_q;
  assign sine_o = sine_q;

endmodule

// ----- rtl/core/csin_checker.sv -----
// Port-level checks for the CORDIC sine block, bound to its top level.
module csin_checker #(
  parameter int ITERATIONS = 20
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic signed [csin_pkg::ANGLE_W-1:0] angle_i,
  input logic                                done_o,
  input logic signed [csin_pkg::SINE_W-1:0]  sine_o
);
  import csin_pkg::*;

  localparam int LAT = ITERATIONS + 3;
  localparam logic signed [SINE_W-1:0]  SINE_MAX = SINE_W'(SINE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] ANG_POS  = ANGLE_W'(4096);
  localparam logic signed [ANGLE_W-1:0] ANG_NEG  = -ANGLE_W'(4096);

  // every transfer in yields a result after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("result missing after accepted angle");

  // no result without a matching transfer in
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without accepted angle");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sine_o <= SINE_MAX) && (sine_o >= -SINE_MAX))
    else $error("sine out of range");

  // clearly positive or negative angles give a sine of the same sign
  a_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!($past(angle_i, LAT) >= ANG_POS) || (sine_o > 0)) &&
               (!($past(angle_i, LAT) <= ANG_NEG) || (sine_o < 0)))
    else $error("sine has wrong sign");

endmodule

bind cordic_sine_rotation csin_checker #(.ITERATIONS(ITERATIONS)) u_csin_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .angle_i (angle_i),
  .done_o  (done_o),
  .sine_o  (sine_o)
);
